[design/rsts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsts_pkg
// Shared types and codes for the strength-ranked scan table.
// ----------------------------------------------------------------------------
package rsts_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam int unsigned ADDR_W          = 48;
	localparam int unsigned ATYPE_W         = 2;
	localparam int unsigned STR_W           = 8;
	localparam int unsigned RANK_W          = 4;
	localparam int unsigned ENTRIES_W       = 5;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MATCH   = 2'd1,
		ST_FULL    = 2'd2,
		ST_NO_RANK = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0]       address;
		logic [ATYPE_W-1:0]      addr_type;
		logic signed [STR_W-1:0] strength;
	} entry_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic eval_en;
		logic apply_we;
	} cell_ctl_t;

endpackage

[design/rsts_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsts_req_if
// Request channel: operation, report fields and rank to read.
// ----------------------------------------------------------------------------
interface rsts_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [47:0]       address;
	logic [1:0]        address_type;
	logic signed [7:0] strength;
	logic [3:0]        rank;

	modport source (output valid, op, address, address_type, strength, rank, input ready);
	modport sink   (input valid, op, address, address_type, strength, rank, output ready);
endinterface

[design/rsts_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsts_rsp_if
// Response channel: status, occupancy and the entry read.
// ----------------------------------------------------------------------------
interface rsts_rsp_if;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [4:0]        entries;
	logic              full_res;
	logic [47:0]       found_address;
	logic [1:0]        found_type;
	logic signed [7:0] found_strength;

	modport source (output valid, status, entries, full_res, found_address, found_type,
		found_strength, input ready);
	modport sink   (input valid, status, entries, full_res, found_address, found_type,
		found_strength, output ready);
endinterface

[design/rsts_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsts_cell
// One slot of the ranked table. Compares the probe against its own entry,
// then on a write takes its new entry from itself, a neighbour or the
// incoming report, so removal and sorted insertion happen in one step.
// ----------------------------------------------------------------------------
module rsts_cell import rsts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int unsigned IDX         = 0,
	localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  entry_t           probe,
	input  entry_t           ins,
	input  logic [CNT_W-1:0] count,
	input  logic [CNT_W-1:0] hit_idx,
	input  entry_t           prev,
	input  entry_t           next,
	input  logic             ge_next,
	input  logic             lt_prev,
	output entry_t           cur,
	output logic             match,
	output logic             changed,
	output logic             ge,
	output logic             lt
);

	entry_t     entry_q;
	logic       ge_s2;
	logic       occ;
	logic       ge_now;
	logic       below_h;
	logic       prev_below_h;
	logic       at_p;
	entry_t     entry_d;

	assign cur     = entry_q;
	assign occ     = CNT_W'(IDX) < count;
	assign match   = occ && (entry_q.address == probe.address)
		&& (entry_q.addr_type == probe.addr_type);
	assign changed = match && (entry_q.strength != probe.strength);
	assign ge_now  = occ && !match && (entry_q.strength >= probe.strength);
	assign ge      = ge_s2;

	// position in the table with the matched entry taken out
	assign below_h      = CNT_W'(IDX) < hit_idx;
	assign prev_below_h = CNT_W'(IDX) <= hit_idx;
	assign lt           = below_h ? ge_s2 : ge_next;
	assign at_p         = !lt && lt_prev;

	always_comb begin
		if (lt) begin
			entry_d = below_h ? entry_q : next;
		end else if (at_p) begin
			entry_d = ins;
		end else begin
			entry_d = prev_below_h ? prev : entry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval_en) begin
			ge_s2 <= ge_now;
		end
		if (ctl.apply_we) begin
			entry_q <= entry_d;
		end
	end

endmodule

[design/rssi_ranked_scan_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_ranked_scan_table
// Table of scanned device addresses kept in order of signal strength,
// strongest first, built as a row of slot cells with a small sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | carries
//  req     | in  | valid / ready | op, address, address_type, strength, rank
//  rsp     | out | valid / ready | status, entries, full_res, found_*
//
//  every item passes two states: S_EVAL, in which all cells compare the report
//  in parallel, then S_APPLY, in which the cell row shifts and inserts in a single step.
//  a new request is also taken in S_APPLY, so an item can be accepted while the last one completes.
//  S_APPLY waits while a previous response is still held on rsp.
//  reset empties the table at once; slot contents are left as they are.
// ----------------------------------------------------------------------------
module rssi_ranked_scan_table import rsts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	rsts_req_if.sink   req,
	rsts_rsp_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic [1:0]        op;
		entry_t            ent;
		logic [RANK_W-1:0] rank;
	} item_t;

	state_t            state_q;
	item_t             item_s1;
	entry_t            ins_s2;
	logic              we_s2;
	logic [CNT_W-1:0]  hit_idx_s2;
	logic [CNT_W-1:0]  count_s2;
	status_t           status_s2;
	entry_t            found_s2;
	logic [CNT_W-1:0]  count_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [CNT_W-1:0]  entries_q;
	entry_t            found_q;

	cell_ctl_t         ctl;
	entry_t            cur [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] match_vec;
	logic [TABLE_DEPTH-1:0] changed_vec;
	logic [TABLE_DEPTH:0]   ge_vec;
	logic [TABLE_DEPTH:0]   lt_vec;

	logic              apply_go;
	logic              accept;
	logic              hit;
	logic              full;
	logic [CNT_W-1:0]  hit_idx;
	logic              rank_ok;
	entry_t            rank_ent;
	status_t           status_d;
	logic              we_d;
	logic [CNT_W-1:0]  count_d;

	assign apply_go  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) || ((state_q == S_APPLY) && apply_go);
	assign accept    = req.valid && req.ready;

	assign ctl.eval_en  = state_q == S_EVAL;
	assign ctl.apply_we = (state_q == S_APPLY) && apply_go && we_s2;

	assign ge_vec[TABLE_DEPTH] = 1'b0;
	assign lt_vec[0]           = 1'b1;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t prev_ent;
		entry_t next_ent;
		if (i == 0) begin : g_first
			assign prev_ent = '0;
		end else begin : g_mid
			assign prev_ent = cur[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign next_ent = '0;
		end else begin : g_inner
			assign next_ent = cur[i+1];
		end
		rsts_cell #(
			.TABLE_DEPTH (TABLE_DEPTH),
			.IDX         (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.probe   (item_s1.ent),
			.ins     (ins_s2),
			.count   (count_q),
			.hit_idx (hit_idx_s2),
			.prev    (prev_ent),
			.next    (next_ent),
			.ge_next (ge_vec[i+1]),
			.lt_prev (lt_vec[i]),
			.cur     (cur[i]),
			.match   (match_vec[i]),
			.changed (changed_vec[i]),
			.ge      (ge_vec[i]),
			.lt      (lt_vec[i+1])
		);
	end

	// address and type pairs are unique in the table, so at most one cell matches
	always_comb begin
		hit_idx = CNT_W'(TABLE_DEPTH);
		for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
			if (match_vec[i]) begin
				hit_idx = CNT_W'(i);
			end
		end
	end

	always_comb begin
		rank_ent = '0;
		for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
			if (32'(item_s1.rank) == i) begin
				rank_ent = cur[i];
			end
		end
	end

	assign hit     = |match_vec;
	assign full    = count_q == CNT_W'(TABLE_DEPTH);
	assign rank_ok = 32'(item_s1.rank) < 32'(count_q);

	always_comb begin
		status_d = ST_OK;
		we_d     = 1'b0;
		count_d  = count_q;
		case (item_s1.op)
			OP_ADD: begin
				if (hit) begin
					status_d = ST_MATCH;
					we_d     = |changed_vec;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					we_d    = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_READ: begin
				if (!rank_ok) begin
					status_d = ST_NO_RANK;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{op: req.op,
				ent: '{address: req.address, addr_type: req.address_type,
					strength: req.strength},
				rank: req.rank};
		end
		if (state_q == S_EVAL) begin
			ins_s2     <= item_s1.ent;
			hit_idx_s2 <= hit ? hit_idx : CNT_W'(TABLE_DEPTH);
			count_s2   <= count_d;
			status_s2  <= status_d;
			found_s2   <= ((item_s1.op == OP_READ) && rank_ok) ? rank_ent : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s2   <= 1'b0;
			count_q <= '0;
		end else begin
			if (state_q == S_EVAL) begin
				we_s2 <= we_d;
			end
			if ((state_q == S_APPLY) && apply_go) begin
				count_q <= count_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			entries_q   <= '0;
			found_q     <= '0;
		end else begin
			if ((state_q == S_APPLY) && apply_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply_go) begin
						status_q    <= status_s2;
						entries_q   <= count_s2;
						found_q     <= found_s2;
						state_q     <= accept ? S_EVAL : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.entries        = ENTRIES_W'(entries_q);
	assign rsp.full_res       = entries_q == CNT_W'(TABLE_DEPTH);
	assign rsp.found_address  = found_q.address;
	assign rsp.found_type     = found_q.addr_type;
	assign rsp.found_strength = found_q.strength;

endmodule

[design/rsts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsts_checker
// Port-level checks on the ranked scan table responses.
// ----------------------------------------------------------------------------
module rsts_checker import rsts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        rsp_status,
	input logic [4:0]        rsp_entries,
	input logic              rsp_full_res,
	input logic [47:0]       rsp_found_address,
	input logic signed [7:0] rsp_found_strength
);

	// a response held under back-pressure keeps its status and entry count
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_entries))
		else $error("response changed while stalled");

	a_entries_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (TABLE_DEPTH > 31) || (32'(rsp_entries) <= TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (TABLE_DEPTH > 31) || (rsp_full_res == (32'(rsp_entries) == TABLE_DEPTH)))
		else $error("full flag disagrees with entry count");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_FULL) |-> rsp_full_res)
		else $error("report dropped while table not full");

	a_no_rank_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NO_RANK)
			|-> (rsp_found_address == '0) && (rsp_found_strength == '0))
		else $error("missing rank returned entry data");

endmodule

bind rssi_ranked_scan_table rsts_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_rsts_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_entries        (rsp.entries),
	.rsp_full_res       (rsp.full_res),
	.rsp_found_address  (rsp.found_address),
	.rsp_found_strength (rsp.found_strength)
);
